/* rtl/pdc_pkg.sv */
// Package for the PID duty controller: word types, register indexes,
// Q16.16 constants and the saturating add helper. No dependencies.
package pdc_pkg;

  // Input word: request kind and temperature
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] temperature;
  } pdc_in_t;

  // Output word
  typedef struct packed {
    logic [7:0]         duty;
    logic               windup;
    logic signed [31:0] filtered_temperature;
  } pdc_out_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN_P = 2'd0,
    CFG_GAIN_I = 2'd1,
    CFG_GAIN_D = 2'd2,
    CFG_TARGET = 2'd3
  } pdc_cfg_idx_e;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_RESET  = 1'b1;

  // Q16.16 constants
  localparam logic signed [31:0] DERIV_KEEP = 32'sh0000_b333;
  localparam logic signed [31:0] DERIV_NEW  = 32'sh0000_4ccd;
  localparam logic signed [31:0] SLOW_KEEP  = 32'sh0000_e666;
  localparam logic signed [31:0] SLOW_NEW   = 32'sh0000_199a;
  localparam logic signed [31:0] START_TEMP = 32'sh0028_0000;
  localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX    = 32'sh7fff_ffff;
  localparam logic signed [33:0] DRIVE_TOP  = 34'sh0_00ff_0000;
  localparam logic [7:0]         DUTY_TOP   = 8'hff;

  // Saturate a 33-bit sum or difference to 32 bits
  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/pid_duty_controller_q16.sv */
// PID duty controller, saturating signed Q16.16. One word is taken at a time:
// in_ready_o is high only while the sequencer is idle. A temperature sample
// passes through the set-up state, eight multiplier steps, clamp and hand-off
// before out_valid_o rises; the seven products all go through the single
// registered multiplier. A reset request goes from set-up straight to the
// hand-off. The next word can be accepted in the cycle after the hand-off. A
// finished word sits in the output register, so the next input word is
// accepted while it waits. Configuration writes are always taken. Depends on
// pdc_pkg and pdc_sat_mul.
module pid_duty_controller_q16 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdc_pkg::pdc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdc_pkg::pdc_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import pdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_MUL   = 5'b00100,
    S_CLAMP = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q;

  // Configuration
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, target_q;

  // Controller state
  logic signed [31:0] integ_q, fd_q, prev_q, slow_q;
  logic               windup_q;
  logic [7:0]         duty_q;

  // Per-word working registers
  logic               req_q;
  logic signed [31:0] temp_q, diff_q, err_q, tmp_q;
  logic signed [33:0] drive_q;

  // Output register
  logic     out_valid_q;
  pdc_out_t out_q;

  // Multiplier operands
  logic signed [31:0] mul_a, mul_b, prod;
  logic signed [31:0] new_prev;
  logic [24:0]        duty_rnd;

  pdc_sat_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign new_prev = (temp_q == S32_MIN) ? prev_q : temp_q;
  assign duty_rnd = {1'b0, drive_q[23:0]} + 25'h0_8000;

  // Operand select for each multiplier step
  always_comb begin
    case (step_q)
      3'd0:    begin mul_a = fd_q;     mul_b = DERIV_KEEP; end
      3'd1:    begin mul_a = diff_q;   mul_b = DERIV_NEW;  end
      3'd2:    begin mul_a = slow_q;   mul_b = SLOW_KEEP;  end
      3'd3:    begin mul_a = temp_q;   mul_b = SLOW_NEW;   end
      3'd4:    begin mul_a = gain_p_q; mul_b = err_q;      end
      3'd5:    begin mul_a = gain_i_q; mul_b = integ_q;    end
      default: begin mul_a = gain_d_q; mul_b = fd_q;       end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_PREP;
      S_PREP:  state_d = (req_q == REQ_RESET) ? S_DONE : S_MUL;
      S_MUL:   if (step_q == 3'd7) state_d = S_CLAMP;
      S_CLAMP: state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      target_q    <= '0;
      integ_q     <= '0;
      fd_q        <= '0;
      prev_q      <= START_TEMP;
      slow_q      <= START_TEMP;
      windup_q    <= 1'b0;
      duty_q      <= '0;
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_valid_i) begin
        unique case (pdc_cfg_idx_e'(cfg_index_i))
          CFG_GAIN_P: gain_p_q <= cfg_data_i;
          CFG_GAIN_I: gain_i_q <= cfg_data_i;
          CFG_GAIN_D: gain_d_q <= cfg_data_i;
          CFG_TARGET: target_q <= cfg_data_i;
          default:    ;
        endcase
      end

      // Reset request handled in the set-up cycle
      if (state_q == S_PREP && req_q == REQ_RESET) begin
        integ_q  <= '0;
        fd_q     <= '0;
        prev_q   <= new_prev;
        slow_q   <= new_prev;
        windup_q <= 1'b0;
        duty_q   <= '0;
      end

      // Multiplier steps: issue step n, consume product of step n-1
      if (state_q == S_PREP) begin
        step_q <= 3'd0;
      end else if (state_q == S_MUL) begin
        step_q <= step_q + 3'd1;
        case (step_q)
          3'd0: begin
            if (!windup_q) begin
              integ_q <= sat33({integ_q[31], integ_q} + {err_q[31], err_q});
            end
            prev_q <= temp_q;
          end
          3'd2:    fd_q   <= sat33({tmp_q[31], tmp_q} + {prod[31], prod});
          3'd4:    slow_q <= sat33({tmp_q[31], tmp_q} + {prod[31], prod});
          default: ;
        endcase
      end

      // Drive clamp and rounding
      if (state_q == S_CLAMP) begin
        if (drive_q > DRIVE_TOP) begin
          duty_q   <= DUTY_TOP;
          windup_q <= 1'b1;
        end else if (drive_q[33]) begin
          duty_q   <= '0;
          windup_q <= 1'b1;
        end else begin
          duty_q   <= duty_rnd[23:16];
          windup_q <= 1'b0;
        end
      end

      // Output handshake
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q  <= in_data_i.req_type;
      temp_q <= in_data_i.temperature;
    end
    if (state_q == S_PREP) begin
      diff_q <= sat33({temp_q[31], temp_q} - {prev_q[31], prev_q});
      err_q  <= sat33({target_q[31], target_q} - {temp_q[31], temp_q});
    end
    if (state_q == S_MUL) begin
      case (step_q)
        3'd1:    tmp_q   <= prod;
        3'd3:    tmp_q   <= prod;
        3'd5:    drive_q <= {{2{prod[31]}}, prod};
        3'd6:    drive_q <= drive_q + {{2{prod[31]}}, prod};
        3'd7:    drive_q <= drive_q + {{2{prod[31]}}, prod};
        default: ;
      endcase
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.duty                 <= duty_q;
      out_q.windup               <= windup_q;
      out_q.filtered_temperature <= slow_q;
    end
  end

endmodule

/* rtl/pdc_sat_mul.sv */
// Shared Q16.16 multiplier: full product, round half up, saturate, register.
// Depends on pdc_pkg.
module pdc_sat_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] p_o
);
  import pdc_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [47:0] shr;
  logic signed [31:0] p_d;
  logic signed [31:0] p_q;

  // Product, add half an LSB, arithmetic shift (floor)
  assign prod = a_i * b_i;
  assign rnd  = prod + 64'sh8000;
  assign shr  = rnd[63:16];

  // Saturate when the top 17 bits disagree
  always_comb begin
    if (shr[47:31] == {17{1'b0}} || shr[47:31] == {17{1'b1}}) begin
      p_d = shr[31:0];
    end else begin
      p_d = shr[47] ? S32_MIN : S32_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
